### sv/e2cd_pkg.sv
// Package for the epoch to calendar date unit: types, constants, helpers.
// Used by e2cd_ctrl, e2cd_datapath and epoch_to_calendar_date_unit.
`default_nettype none

package e2cd_pkg;

  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] SecsPerMin  = 17'd60;

  // quotient = (x * ceil(2^k / d)) >> k, exact over the pre-shifted operand range
  localparam logic [25:0] DayRecip  = 26'd50903317;  // 86400 = 128 * 675, k = 35
  localparam logic [13:0] HourRecip = 14'd9321;      // 3600 = 16 * 225, k = 21
  localparam logic [10:0] MinRecip  = 11'd1093;      // 60 = 4 * 15, k = 14

  localparam logic [11:0] BaseYear   = 12'd1970;
  localparam logic [6:0]  BaseMod100 = 7'd70;
  localparam logic [8:0]  BaseMod400 = 9'd370;
  localparam logic [2:0]  BaseWday   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAYQ,
    S_DAYR,
    S_HOURQ,
    S_HOURR,
    S_MINQ,
    S_MINR,
    S_YEAR,
    S_MONTH,
    S_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_EPOCH,
    OP_DIV_QUOT,
    OP_DIV_REM,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_e;

  typedef struct packed {
    op_e      op;
    div_sel_e div_sel;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
      4'd1:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

  // x is at most 36
  function automatic logic [2:0] mod7_small(input logic [5:0] x);
    logic [5:0] r;
    if (x >= 6'd35) begin
      r = x - 6'd35;
    end else if (x >= 6'd28) begin
      r = x - 6'd28;
    end else if (x >= 6'd21) begin
      r = x - 6'd21;
    end else if (x >= 6'd14) begin
      r = x - 6'd14;
    end else if (x >= 6'd7) begin
      r = x - 6'd7;
    end else begin
      r = x;
    end
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

### sv/e2cd_ctrl.sv
// Controller for the epoch to calendar date unit: sequencer and output valid.
// Depends on e2cd_pkg; drives e2cd_datapath through cmd_t, reads status_t.
`default_nettype none

module e2cd_ctrl import e2cd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e     state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.div_sel = DIV_DAY;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD_EPOCH;
          state_d  = S_DAYQ;
        end
      end
      S_DAYQ: begin
        cmd_o.op      = OP_DIV_QUOT;
        cmd_o.div_sel = DIV_DAY;
        state_d       = S_DAYR;
      end
      S_DAYR: begin
        cmd_o.op      = OP_DIV_REM;
        cmd_o.div_sel = DIV_DAY;
        state_d       = S_HOURQ;
      end
      S_HOURQ: begin
        cmd_o.op      = OP_DIV_QUOT;
        cmd_o.div_sel = DIV_HOUR;
        state_d       = S_HOURR;
      end
      S_HOURR: begin
        cmd_o.op      = OP_DIV_REM;
        cmd_o.div_sel = DIV_HOUR;
        state_d       = S_MINQ;
      end
      S_MINQ: begin
        cmd_o.op      = OP_DIV_QUOT;
        cmd_o.div_sel = DIV_MIN;
        state_d       = S_MINR;
      end
      S_MINR: begin
        cmd_o.op      = OP_DIV_REM;
        cmd_o.div_sel = DIV_MIN;
        state_d       = S_YEAR;
      end
      S_YEAR: begin
        if (status_i.year_done) begin
          state_d = S_MONTH;
        end else begin
          cmd_o.op = OP_YEAR_STEP;
        end
      end
      S_MONTH: begin
        if (status_i.month_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_MONTH_STEP;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_FINISH) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_fin_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_FINISH) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD_EPOCH) |=> (state_q == S_DAYQ))
    else $error("day division not started after input transfer");

  a_min_to_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MINR) |=> (state_q == S_YEAR))
    else $error("year walk not entered after minute division");

endmodule

`default_nettype wire

### sv/e2cd_datapath.sv
// Datapath for the epoch to calendar date unit: reciprocal constant dividers,
// year and month walks, weekday tracking and result registers. Uses e2cd_pkg.
`default_nettype none

module e2cd_datapath import e2cd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic [31:0] epoch_seconds_i,
  output status_t          status_o,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_of_month_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o,
  output logic [2:0]       weekday_o
);

  logic [31:0] num_q;
  logic [16:0] rem_q;
  logic [15:0] days_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;
  logic [11:0] year_q;
  logic [6:0]  c100_q;
  logic [8:0]  c400_q;
  logic [3:0]  midx_q;
  logic [2:0]  wd_q;

  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [16:0] day_back;
  logic [11:0] hour_back;
  logic [5:0]  min_back;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  assign day_prod  = 51'(num_q[31:7]) * 51'(DayRecip);
  assign hour_prod = 27'(rem_q[16:4]) * 27'(HourRecip);
  assign min_prod  = 21'(rem_q[11:2]) * 21'(MinRecip);
  assign day_back  = 17'({1'b0, days_q} * SecsPerDay);
  assign hour_back = 12'({12'd0, hour_q} * SecsPerHour);
  assign min_back  = 6'({11'd0, min_q} * SecsPerMin);

  assign leap = ((year_q[1:0] == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(midx_q, leap);

  assign status_o.year_done  = days_q < {7'd0, ylen};
  assign status_o.month_done = days_q < {11'd0, mlen};

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD_EPOCH: begin
        num_q <= epoch_seconds_i;
      end
      OP_DIV_QUOT: begin
        case (cmd_i.div_sel)
          DIV_DAY:  days_q <= day_prod[50:35];
          DIV_HOUR: hour_q <= hour_prod[25:21];
          DIV_MIN:  min_q  <= min_prod[19:14];
          default: begin
          end
        endcase
      end
      OP_DIV_REM: begin
        case (cmd_i.div_sel)
          DIV_DAY: begin
            rem_q  <= num_q[16:0] - day_back;
            year_q <= BaseYear;
            c100_q <= BaseMod100;
            c400_q <= BaseMod400;
            midx_q <= '0;
            wd_q   <= BaseWday;
          end
          DIV_HOUR: rem_q <= {5'd0, rem_q[11:0] - hour_back};
          DIV_MIN:  sec_q <= rem_q[5:0] - min_back;
          default: begin
          end
        endcase
      end
      OP_YEAR_STEP: begin
        days_q <= days_q - {7'd0, ylen};
        year_q <= year_q + 12'd1;
        c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
        c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        wd_q   <= mod7_small({3'd0, wd_q} + (leap ? 6'd2 : 6'd1));
      end
      OP_MONTH_STEP: begin
        days_q <= days_q - {11'd0, mlen};
        midx_q <= midx_q + 4'd1;
        wd_q   <= mod7_small({3'd0, wd_q} + {1'b0, mlen - 5'd28});
      end
      OP_FINISH: begin
        year_o         <= year_q;
        month_o        <= midx_q + 4'd1;
        day_of_month_o <= days_q[4:0] + 5'd1;
        hour_o         <= hour_q;
        minute_o       <= min_q;
        second_o       <= sec_q;
        weekday_o      <= mod7_small({3'd0, wd_q} + {1'b0, days_q[4:0]});
      end
      default: begin
      end
    endcase
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIV_QUOT && cmd_i.div_sel == DIV_MIN) |-> (rem_q < SecsPerHour))
    else $error("hour remainder out of range");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIV_REM && cmd_i.div_sel == DIV_MIN) |->
      (hour_q < 5'd24 && min_q < 6'd60))
    else $error("hour or minute quotient out of range");

  a_leap_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_YEAR_STEP) |-> (year_q[1:0] == c400_q[1:0]))
    else $error("year and mod-400 counter disagree");

  a_month_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MONTH_STEP) |-> (midx_q < 4'd11))
    else $error("month walk ran past December");

  a_day_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FINISH) |-> (days_q < 16'd31))
    else $error("day of month out of range");

endmodule

`default_nettype wire

### sv/epoch_to_calendar_date_unit.sv
// Top level of the epoch to calendar date unit.
// Instantiates e2cd_ctrl and e2cd_datapath; uses e2cd_pkg.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | in_valid_i, in_ready_o, epoch_seconds_i | in
//   result  | out_valid_o, out_ready_i, year_o .. weekday_o | out
//
// From input transfer to result, the sequencer computes reciprocal quotient and
// remainder for 86400, 3600 and 60, walks Y whole years (0 to 136) and M months
// (0 to 11), closes each walk and then loads the result register.
// One item is in work at a time; ready is high only while the sequencer is idle.
// An untaken result stalls the load of the next one; reset clears state and valid.
`default_nettype none

module epoch_to_calendar_date_unit import e2cd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] epoch_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_of_month_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o,
  output logic [2:0]       weekday_o
);

  cmd_t    cmd;
  status_t status;

  e2cd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  e2cd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .epoch_seconds_i (epoch_seconds_i),
    .status_o        (status),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o),
    .weekday_o       (weekday_o)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for epoch_to_calendar_date_unit: directed and random epoch
// counts, randomly paced valid/ready on both sides, results checked against a date predictor.
// Depends only on the RTL of the unit.
module tb_top;

  typedef enum logic [2:0] {SUN, MON, TUE, WED, THU, FRI, SAT} wday_e;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  wday;
  } cal_date_t;

  typedef struct packed {
    logic [31:0] epoch;
    cal_date_t   date;
  } pending_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic        typed;
    cal_date_t   date;
  } dir_row_t;

  localparam int unsigned DaySecs  = 86400;
  localparam int unsigned HourSecs = 3600;
  localparam int unsigned MinSecs  = 60;
  localparam int unsigned EpochYear = 1970;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int RandItems  = 430;
  localparam int DrainWait  = 250;
  localparam int NumDir     = 22;
  localparam int MaxPrinted = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] epoch_seconds_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic [2:0]  weekday_o;

  pending_t pending_dates [$];
  int       mismatches = 0;
  bit       tx_burst = 1'b0;
  bit       rx_burst = 1'b0;

  dir_row_t dir_rows [NumDir] = '{
    '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1,  5'd0,  6'd0,  6'd0,  THU}},
    '{32'd59,         1'b0, '0},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1,  5'd23, 6'd59, 6'd59, THU}},
    '{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2,  5'd0,  6'd0,  6'd0,  FRI}},
    '{32'd31535999,   1'b0, '0},
    '{32'd31536000,   1'b0, '0},
    '{32'd68169600,   1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'd946684800,  1'b0, '0},
    '{32'd951782400,  1'b1, '{12'd2000, 4'd2, 5'd29, 5'd0,  6'd0,  6'd0,  TUE}},
    '{32'd1000000000, 1'b1, '{12'd2001, 4'd9, 5'd9,  5'd1,  6'd46, 6'd40, SUN}},
    '{32'd2147483647, 1'b1, '{12'd2038, 4'd1, 5'd19, 5'd3,  6'd14, 6'd7,  TUE}},
    '{32'h8000_0000,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'd4294944000, 1'b0, '0},
    '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7,  5'd6,  6'd28, 6'd15, SUN}}
  };

  epoch_to_calendar_date_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .epoch_seconds_i(epoch_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .weekday_o      (weekday_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic cal_date_t calc_calendar_date(input logic [31:0] epoch);
    int unsigned days, secs, total, yr, ylen, mlen;
    cal_date_t   d;
    days  = epoch / DaySecs;
    secs  = epoch % DaySecs;
    total = days;
    yr    = EpochYear;
    ylen  = leap_year(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = leap_year(yr) ? 366 : 365;
    end
    d.month = 4'd12;
    for (int m = 0; m < 12; m++) begin
      mlen = (m == 1 && leap_year(yr)) ? 29 : MonthDays[m];
      if (days < mlen) begin
        d.month = 4'(m + 1);
        break;
      end
      days -= mlen;
    end
    d.year   = 12'(yr);
    d.mday   = 5'(days + 1);
    d.hour   = 5'(secs / HourSecs);
    d.minute = 6'((secs % HourSecs) / MinSecs);
    d.second = 6'(secs % MinSecs);
    d.wday   = 3'((total + 4) % 7);
    return d;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] epoch,
                               input int got, input int want);
    if (got != want)
      log_mismatch($sformatf("epoch %0d %s got %0d expected %0d", epoch, name, got, want));
  endtask

  // one input transfer; expectation is queued at the accepting edge
  task automatic send_epoch(input logic [31:0] epoch, input bit typed, input cal_date_t date);
    int gap;
    pending_t p;
    if ($urandom_range(0, 23) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= epoch;
    do @(posedge clk_i); while (!in_ready_o);
    p.epoch = epoch;
    p.date  = typed ? date : calc_calendar_date(epoch);
    pending_dates.push_back(p);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int          kind, yr, mo;
    int unsigned days;
    logic [63:0] wide;
    logic [31:0] epoch;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_epoch(dir_rows[i].epoch, dir_rows[i].typed, dir_rows[i].date);
    wait_drained();

    for (int i = 0; i < RandItems; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // around a month or year boundary
        yr   = $urandom_range(1970, 2106);
        mo   = $urandom_range(0, 11);
        days = 0;
        for (int y = EpochYear; y < yr; y++) days += leap_year(y) ? 366 : 365;
        for (int m = 0; m < mo; m++) days += (m == 1 && leap_year(yr)) ? 29 : MonthDays[m];
        wide  = 64'(days) * DaySecs + 64'($urandom_range(0, 7200)) - 64'd3600;
        epoch = wide[31:0];
      end else if (kind < 70) begin
        epoch = $urandom();
      end else if (kind < 85) begin
        epoch = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
      end else begin
        epoch = $urandom_range(0, 1_000_000_000);
      end
      if (i == RandItems / 2) wait_drained();
      send_epoch(epoch, 1'b0, '0);
    end

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int        stall;
    cal_date_t got;
    pending_t  p;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{year_o, month_o, day_of_month_o, hour_o, minute_o, second_o, weekday_o};
      if (pending_dates.size() == 0) begin
        log_mismatch($sformatf("unexpected transfer %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                               got.year, got.month, got.mday, got.hour, got.minute,
                               got.second, got.wday));
      end else begin
        p = pending_dates.pop_front();
        compare_field("year",         p.epoch, got.year,   p.date.year);
        compare_field("month",        p.epoch, got.month,  p.date.month);
        compare_field("day_of_month", p.epoch, got.mday,   p.date.mday);
        compare_field("hour",         p.epoch, got.hour,   p.date.hour);
        compare_field("minute",       p.epoch, got.minute, p.date.minute);
        compare_field("second",       p.epoch, got.second, p.date.second);
        compare_field("weekday",      p.epoch, got.wday,   p.date.wday);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
